// ===== hw/rtl/rhc_pkg.sv =====
// shared types, constants and the divider step of the rgb/hsv converter
`timescale 1ns / 1ps
package rhc_pkg;

    typedef enum logic {
        FUNC_RGB2HSV = 1'b0,
        FUNC_HSV2RGB = 1'b1
    } t_func;

    // hue sectors of 60 degrees
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    localparam int QBITS  = 9;   // quotient bits, every quotient stays below 512
    localparam int NBITS  = 23;  // dividend / remainder width
    localparam int DBITS  = 15;  // divisor width
    localparam int NDIV   = 10;  // operand stage plus one stage per quotient bit

    localparam logic [8:0]  HUE_FULL = 9'd360;
    localparam logic [NBITS-1:0] MID_BIAS = 23'd15300;
    localparam logic [DBITS-1:0] MID_DEN  = 15'd30600;
    localparam logic [DBITS-1:0] LO_DEN   = 15'd510;

    typedef struct packed {
        t_func       func;
        logic [7:0]  alpha;
        logic [7:0]  v;
        logic [2:0]  sector;
        logic [7:0]  c;
        logic [17:0] num;
        logic [15:0] p1;
        logic [15:0] vs;
        logic [5:0]  t;
    } t_pre;

    typedef struct packed {
        t_func            func;
        logic [7:0]       alpha;
        logic [7:0]       v;
        logic [2:0]       sector;
        logic             zc;
        logic             zm;
        logic [NBITS-1:0] n0;
        logic [DBITS-1:0] d0;
        logic [QBITS-1:0] q0;
        logic [NBITS-1:0] n1;
        logic [DBITS-1:0] d1;
        logic [QBITS-1:0] q1;
    } t_div;

    // one restoring step on both lanes, quotient bit b
    function automatic t_div div_step(t_div x, logic [3:0] b);
        logic [NBITS:0] dsh0;
        logic [NBITS:0] dsh1;
        t_div y;
        y    = x;
        dsh0 = {{(NBITS-DBITS+1){1'b0}}, x.d0} << b;
        dsh1 = {{(NBITS-DBITS+1){1'b0}}, x.d1} << b;
        if ({1'b0, x.n0} >= dsh0) begin
            y.n0    = x.n0 - dsh0[NBITS-1:0];
            y.q0[b] = 1'b1;
        end
        if ({1'b0, x.n1} >= dsh1) begin
            y.n1    = x.n1 - dsh1[NBITS-1:0];
            y.q1[b] = 1'b1;
        end
        return y;
    endfunction

endpackage

// ===== hw/rtl/rhc_if.sv =====
// pixel channel interfaces: input items and result items
`timescale 1ns / 1ps
interface rhc_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [8:0] in_first;
    logic [7:0] in_second;
    logic [7:0] in_third;
    logic [7:0] in_alpha;
    modport source (output valid, func, in_first, in_second, in_third, in_alpha, input ready);
    modport sink   (input valid, func, in_first, in_second, in_third, in_alpha, output ready);
endinterface

interface rhc_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
    logic [7:0] out_alpha;
    modport source (output valid, out_first, out_second, out_third, out_alpha, input ready);
    modport sink   (input valid, out_first, out_second, out_third, out_alpha, output ready);
endinterface

// ===== hw/rtl/rgb_hsv_converter.sv =====
// top level of the rgb/hsv pixel converter
// usage
//   i_pix carries one pixel per item: func picks rgb to hsv or hsv to rgb,
//   in_first/second/third are r,g,b or hue,sat,value, in_alpha passes through
//   o_pix carries one result item per input item, in order
//   an item is moved on a rising edge with valid and ready both high
// stages and throughput
//   the accepting edge loads the first of twelve register stages, one for
//   max/min, sector and products, one for the divider operands, nine for
//   the restoring divider (one quotient bit per stage) and one output stage
//   that drives o_pix.valid
//   one item per cycle sustained while o_pix.ready stays high
// reset
//   i_rst_n low at a clock edge empties every stage; no payload is cleared
// stalls
//   each stage holds while it is full and the stage after it is held, so a
//   stalled receiver fills the pipe before i_pix.ready drops; bubbles close up
`timescale 1ns / 1ps
module rgb_hsv_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_in_if.sink     i_pix,
    rhc_out_if.source  o_pix
);
    import rhc_pkg::*;

    // pipeline registers and their valid bits
    t_pre        r_pre;
    logic        r_vld_pre;
    t_div        r_div [NDIV];
    logic [NDIV-1:0] r_vld_div;
    logic [8:0]  r_first;
    logic [7:0]  r_second;
    logic [7:0]  r_third;
    logic [7:0]  r_alpha;
    logic        r_vld_out;

    t_pre        n_pre;
    t_div        n_opd;
    t_div        n_step [NDIV];
    logic [8:0]  n_first;
    logic [7:0]  n_second;
    logic [7:0]  n_third;

    // ready chain, a stage moves when empty or when its successor moves
    logic        rdy_out;
    logic [NDIV-1:0] rdy_div;
    logic        rdy_pre;

    always_comb begin
        rdy_out = !r_vld_out || o_pix.ready;
        rdy_div[NDIV-1] = !r_vld_div[NDIV-1] || rdy_out;
        for (int k = NDIV - 2; k >= 0; k--) begin
            rdy_div[k] = !r_vld_div[k] || rdy_div[k+1];
        end
        rdy_pre = !r_vld_pre || rdy_div[0];
    end

    assign i_pix.ready = rdy_pre;

    // first stage: max/min and hue numerator, or hue sector and products
    always_comb begin
        logic [7:0] r, g, b, mx, mn;
        logic [8:0] h;
        logic [5:0] f;
        h = '0;
        f = '0;
        r = (i_pix.in_first > 9'd255) ? 8'hFF : i_pix.in_first[7:0];
        g = i_pix.in_second;
        b = i_pix.in_third;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        n_pre = '0;
        n_pre.func  = t_func'(i_pix.func);
        n_pre.alpha = i_pix.in_alpha;
        if (n_pre.func == FUNC_RGB2HSV) begin
            n_pre.v = mx;
            n_pre.c = mx - mn;
            // the numerator stays non-negative, so modulo arithmetic is exact
            priority if (mx == r) begin
                n_pre.num = 18'(n_pre.c) * 18'd360 + 18'(g) * 18'd60 - 18'(b) * 18'd60;
            end else if (mx == g) begin
                n_pre.num = 18'(n_pre.c) * 18'd120 + 18'(b) * 18'd60 - 18'(r) * 18'd60;
            end else begin
                n_pre.num = 18'(n_pre.c) * 18'd240 + 18'(r) * 18'd60 - 18'(g) * 18'd60;
            end
        end else begin
            h = (i_pix.in_first >= HUE_FULL) ? i_pix.in_first - HUE_FULL : i_pix.in_first;
            priority if (h < 9'd60) begin
                n_pre.sector = SEC_0;
                f = 6'(h);
            end else if (h < 9'd120) begin
                n_pre.sector = SEC_1;
                f = 6'(h - 9'd60);
            end else if (h < 9'd180) begin
                n_pre.sector = SEC_2;
                f = 6'(h - 9'd120);
            end else if (h < 9'd240) begin
                n_pre.sector = SEC_3;
                f = 6'(h - 9'd180);
            end else if (h < 9'd300) begin
                n_pre.sector = SEC_4;
                f = 6'(h - 9'd240);
            end else begin
                n_pre.sector = SEC_5;
                f = 6'(h - 9'd300);
            end
            n_pre.v  = i_pix.in_third;
            n_pre.t  = n_pre.sector[0] ? 6'd60 - f : f;
            n_pre.p1 = 16'(i_pix.in_third) * 16'(8'd255 - i_pix.in_second);
            n_pre.vs = 16'(i_pix.in_third) * 16'(i_pix.in_second);
        end
    end

    // second stage: rounded-division operands, (2n + d) / 2d
    always_comb begin
        logic [21:0] mid;
        n_opd = '0;
        n_opd.func   = r_pre.func;
        n_opd.alpha  = r_pre.alpha;
        n_opd.v      = r_pre.v;
        n_opd.sector = r_pre.sector;
        n_opd.zc     = (r_pre.c == 8'd0);
        n_opd.zm     = (r_pre.v == 8'd0);
        mid = 22'(r_pre.p1) * 22'd60 + 22'(r_pre.vs) * 22'(r_pre.t);
        if (r_pre.func == FUNC_RGB2HSV) begin
            n_opd.n0 = {4'b0, r_pre.num, 1'b0} + NBITS'(r_pre.c);
            n_opd.d0 = {6'b0, r_pre.c, 1'b0};
            n_opd.n1 = NBITS'(r_pre.c) * 23'd510 + NBITS'(r_pre.v);
            n_opd.d1 = {6'b0, r_pre.v, 1'b0};
        end else begin
            n_opd.n0 = {mid, 1'b0} + MID_BIAS;
            n_opd.d0 = MID_DEN;
            n_opd.n1 = {6'b0, r_pre.p1, 1'b0} + 23'd255;
            n_opd.d1 = LO_DEN;
        end
    end

    // divider stages, most significant quotient bit first
    assign n_step[0] = n_opd;
    for (genvar k = 1; k < NDIV; k++) begin : g_div
        assign n_step[k] = div_step(r_div[k-1], 4'(NDIV - 1 - k));
    end

    // last stage: hue wrap and zero cases, or the six-sector table
    always_comb begin
        t_div x;
        logic [7:0] mid, lo;
        x = r_div[NDIV-1];
        mid = x.q0[7:0];
        lo  = x.q1[7:0];
        n_first  = '0;
        n_second = '0;
        n_third  = '0;
        if (x.func == FUNC_RGB2HSV) begin
            if (!x.zc) begin
                n_first = (x.q0 >= HUE_FULL) ? x.q0 - HUE_FULL : x.q0;
            end
            n_second = x.zm ? 8'd0 : x.q1[7:0];
            n_third  = x.v;
        end else begin
            unique case (x.sector)
                SEC_0: begin n_first = {1'b0, x.v}; n_second = mid;  n_third = lo;  end
                SEC_1: begin n_first = {1'b0, mid}; n_second = x.v;  n_third = lo;  end
                SEC_2: begin n_first = {1'b0, lo};  n_second = x.v;  n_third = mid; end
                SEC_3: begin n_first = {1'b0, lo};  n_second = mid;  n_third = x.v; end
                SEC_4: begin n_first = {1'b0, mid}; n_second = lo;   n_third = x.v; end
                default: begin n_first = {1'b0, x.v}; n_second = lo; n_third = mid; end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pre <= 1'b0;
            r_vld_div <= '0;
            r_vld_out <= 1'b0;
        end else begin
            if (rdy_pre) r_vld_pre <= i_pix.valid;
            if (rdy_div[0]) r_vld_div[0] <= r_vld_pre;
            for (int k = 1; k < NDIV; k++) begin
                if (rdy_div[k]) r_vld_div[k] <= r_vld_div[k-1];
            end
            if (rdy_out) r_vld_out <= r_vld_div[NDIV-1];
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (rdy_pre) r_pre <= n_pre;
        for (int k = 0; k < NDIV; k++) begin
            if (rdy_div[k]) r_div[k] <= n_step[k];
        end
        if (rdy_out) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
            r_alpha  <= r_div[NDIV-1].alpha;
        end
    end

    assign o_pix.valid      = r_vld_out;
    assign o_pix.out_first  = r_first;
    assign o_pix.out_second = r_second;
    assign o_pix.out_third  = r_third;
    assign o_pix.out_alpha  = r_alpha;

endmodule

// ===== hw/rtl/rhc_checker.sv =====
// port-level checks of the converter, bound to the top level
`timescale 1ns / 1ps
module rhc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [8:0] i_out_first,
    input logic [7:0] i_out_alpha
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_first)
            && $stable(i_out_alpha))
        else $error("stalled result item changed or vanished");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input held while the receiver takes items");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_first < 9'd360)
        else $error("first result field out of range");

endmodule

bind rgb_hsv_converter rhc_checker u_rhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_first (o_pix.out_first),
    .i_out_alpha (o_pix.out_alpha)
);
